>>> design/ir_pulse_distance_frame_sender_assert.svh
// Assertion macros for the frame sender RTL, included by irpd_core.
// Expects clk and rst_n in the scope of the including module.
`ifndef IR_PULSE_DISTANCE_FRAME_SENDER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_SENDER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define IRPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define IRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/irpd_pkg.sv
// Package for the pulse-distance IR frame sender: types, widths, constants.
// No dependencies; used by irpd_cfg, irpd_core and the top level.
package irpd_pkg;

  localparam int CNT_W  = 13;
  localparam int TICK_W = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [3:0] MAX_BYTES = 4'd8;

  // Frame phases
  typedef enum logic [1:0] {
    PH_HDR_MARK  = 2'd0,
    PH_HDR_SPACE = 2'd1,
    PH_DATA      = 2'd2,
    PH_STOP      = 2'd3
  } phase_t;

  // Timing and payload settings seen by the frame engine
  typedef struct packed {
    logic [63:0]       payload;
    logic [3:0]        byte_count;
    logic [TICK_W-1:0] header_mark_ticks;
    logic [TICK_W-1:0] header_space_ticks;
    logic [TICK_W-1:0] bit_mark_ticks;
    logic [TICK_W-1:0] one_bit_ticks;
    logic [TICK_W-1:0] zero_bit_ticks;
    logic [TICK_W-1:0] frame_end_ticks;
  } cfg_t;

  // Byte count clamped to 1..MAX_BYTES
  function automatic logic [3:0] bytes_in_frame(input logic [3:0] cnt);
    logic [3:0] n;
    n = cnt;
    if (n < 4'd1) n = 4'd1;
    if (n > MAX_BYTES) n = MAX_BYTES;
    return n;
  endfunction

endpackage

>>> design/irpd_cfg.sv
// APB-style register file for the frame sender settings.
// Depends on irpd_pkg for cfg_t.
module irpd_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output irpd_pkg::cfg_t       cfg
);
  import irpd_pkg::*;

  localparam logic [2:0] REG_PAYLOAD   = 3'd0;
  localparam logic [2:0] REG_BYTE_CNT  = 3'd1;
  localparam logic [2:0] REG_HDR_MARK  = 3'd2;
  localparam logic [2:0] REG_HDR_SPACE = 3'd3;
  localparam logic [2:0] REG_BIT_MARK  = 3'd4;
  localparam logic [2:0] REG_ONE_BIT   = 3'd5;
  localparam logic [2:0] REG_ZERO_BIT  = 3'd6;
  localparam logic [2:0] REG_FRAME_END = 3'd7;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes; reset loads the default frame timing, byte count and a zero payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload            <= 64'd0;
      cfg_r.byte_count         <= 4'd8;
      cfg_r.header_mark_ticks  <= 12'd345;
      cfg_r.header_space_ticks <= 12'd173;
      cfg_r.bit_mark_ticks     <= 12'd21;
      cfg_r.one_bit_ticks      <= 12'd86;
      cfg_r.zero_bit_ticks     <= 12'd43;
      cfg_r.frame_end_ticks    <= 12'd3000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAYLOAD:   cfg_r.payload            <= pwdata;
        REG_BYTE_CNT:  cfg_r.byte_count         <= pwdata[3:0];
        REG_HDR_MARK:  cfg_r.header_mark_ticks  <= pwdata[TICK_W-1:0];
        REG_HDR_SPACE: cfg_r.header_space_ticks <= pwdata[TICK_W-1:0];
        REG_BIT_MARK:  cfg_r.bit_mark_ticks     <= pwdata[TICK_W-1:0];
        REG_ONE_BIT:   cfg_r.one_bit_ticks      <= pwdata[TICK_W-1:0];
        REG_ZERO_BIT:  cfg_r.zero_bit_ticks     <= pwdata[TICK_W-1:0];
        REG_FRAME_END: cfg_r.frame_end_ticks    <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      REG_PAYLOAD:   prdata = cfg_r.payload;
      REG_BYTE_CNT:  prdata = {60'd0, cfg_r.byte_count};
      REG_HDR_MARK:  prdata = {52'd0, cfg_r.header_mark_ticks};
      REG_HDR_SPACE: prdata = {52'd0, cfg_r.header_space_ticks};
      REG_BIT_MARK:  prdata = {52'd0, cfg_r.bit_mark_ticks};
      REG_ONE_BIT:   prdata = {52'd0, cfg_r.one_bit_ticks};
      REG_ZERO_BIT:  prdata = {52'd0, cfg_r.zero_bit_ticks};
      REG_FRAME_END: prdata = {52'd0, cfg_r.frame_end_ticks};
      default:       prdata = 64'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> design/irpd_core.sv
// Frame engine: phase sequencer, tick counter, bit/byte tracking, carrier gate.
// Depends on irpd_pkg and the assertion macro header.
module irpd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  irpd_pkg::cfg_t     cfg,
  output logic               carrier_on,
  output irpd_pkg::phase_t   phase,
  output logic [2:0]         byte_position,
  output logic [2:0]         bit_position
);
  import irpd_pkg::*;
  `include "ir_pulse_distance_frame_sender_assert.svh"

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [2:0]       bits_r, bits_nxt;
  logic [2:0]       byte_r, byte_nxt;
  logic             gate_r, gate_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       cur_byte;
  logic [7:0]       shift_cur;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] hm, hs, bm, fe;
  logic             in_mark;
  logic             past_limit;
  logic             bit_done;
  logic             last_byte;
  logic [3:0]       byte_inc;

  // Shared arithmetic for this tick
  assign cnt_inc    = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign hm         = {1'b0, cfg.header_mark_ticks};
  assign hs         = {1'b0, cfg.header_space_ticks};
  assign bm         = {1'b0, cfg.bit_mark_ticks};
  assign fe         = {1'b0, cfg.frame_end_ticks};
  assign cur_byte   = cfg.payload[{~byte_r, 3'b000} +: 8];
  assign shift_cur  = (bits_r == 3'd0) ? cur_byte : shift_r;
  assign limit      = shift_cur[7] ? {1'b0, cfg.one_bit_ticks} : {1'b0, cfg.zero_bit_ticks};
  assign in_mark    = cnt_inc < bm;
  assign past_limit = cnt_inc > limit;
  assign byte_inc   = {1'b0, byte_r} + 4'd1;
  assign last_byte  = byte_inc >= bytes_in_frame(cfg.byte_count);

  // Next phase and tick counter
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bit_done  = 1'b0;
    if (step) begin
      cnt_nxt = cnt_inc;
      case (phase_r)
        PH_HDR_MARK: begin
          if (cnt_inc >= hm) begin
            phase_nxt = PH_HDR_SPACE;
            cnt_nxt   = '0;
          end
        end
        PH_HDR_SPACE: begin
          if (cnt_inc >= hs) begin
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
          end
        end
        PH_DATA: begin
          if (!in_mark && past_limit) begin
            bit_done = 1'b1;
            cnt_nxt  = '0;
            if (bits_r == 3'd7 && last_byte) phase_nxt = PH_STOP;
          end
        end
        PH_STOP: begin
          if (!in_mark && cnt_inc >= fe) begin
            phase_nxt = PH_HDR_MARK;
            cnt_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Data bit shifting and position tracking
  always_comb begin
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    byte_nxt  = byte_r;
    if (step && phase_r == PH_DATA) begin
      shift_nxt = shift_cur;
      if (bit_done) begin
        shift_nxt = {shift_cur[6:0], 1'b0};
        bits_nxt  = bits_r + 3'd1;
        if (bits_r == 3'd7) byte_nxt = last_byte ? 3'd0 : byte_inc[2:0];
      end
    end
  end

  // Carrier gate; holds on the tick that finishes a bit or the gap
  always_comb begin
    gate_nxt = gate_r;
    if (step) begin
      case (phase_r)
        PH_HDR_MARK:  gate_nxt = 1'b1;
        PH_HDR_SPACE: gate_nxt = 1'b0;
        PH_DATA: begin
          if (in_mark)          gate_nxt = 1'b1;
          else if (!past_limit) gate_nxt = 1'b0;
        end
        PH_STOP: begin
          if (in_mark)       gate_nxt = 1'b1;
          else if (cnt_inc < fe) gate_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR_MARK;
      cnt_r   <= '0;
      shift_r <= 8'd0;
      bits_r  <= 3'd0;
      byte_r  <= 3'd0;
      gate_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      byte_r  <= byte_nxt;
      gate_r  <= gate_nxt;
    end
  end

  assign carrier_on    = gate_r;
  assign phase         = phase_r;
  assign byte_position = byte_r;
  assign bit_position  = bits_r;

  `IRPD_ASSERT_NEXT(a_hold_without_step, !step, $stable(phase_r) && $stable(cnt_r) && $stable(gate_r) && $stable(bits_r) && $stable(byte_r), "state changed without a tick")
  `IRPD_ASSERT_IMPL(a_bits_only_in_data, bits_r != 3'd0, phase_r == PH_DATA, "partial byte outside data phase")
  `IRPD_ASSERT_IMPL(a_data_exit_to_stop, phase_r == PH_DATA && phase_nxt != PH_DATA, phase_nxt == PH_STOP && bits_nxt == 3'd0 && byte_nxt == 3'd0, "bad exit from data phase")
  `IRPD_ASSERT_IMPL(a_phase_change_clears_cnt, phase_nxt != phase_r, cnt_nxt == '0, "counter not cleared on phase change")

endmodule

>>> design/ir_pulse_distance_frame_sender.sv
// Pulse-distance IR frame sender: items with a tick flag in, one status item out per item.
// The input stage registers the accepted item; the state registers update when it advances.
// Throughput: one item per clock unless stalled; the state update is one pass of compares.
// The frame state registers double as the result register; a stalled result holds them.
// Reset (rst_n low, synchronous): header-mark phase, carrier on, counters zero,
// settings at their defaults; no clearing pass.
module ir_pulse_distance_frame_sender (
  input  logic        clk,
  input  logic        rst_n,
  // input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] tick, [7:1] zero
  // result item stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] carrier_on, [2:1] phase, [5:3] byte_position,
                                  // [8:6] bit_position, [15:9] zero
  // settings port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import irpd_pkg::*;

  cfg_t   cfg;
  logic   stg_vld_r, stg_vld_nxt;
  logic   stg_tick_r;
  logic   out_vld_r, out_vld_nxt;
  logic   in_acc;
  logic   advance;
  logic   carrier_on;
  phase_t phase;
  logic [2:0] byte_position;
  logic [2:0] bit_position;

  irpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Handshake: the staged item advances when the result slot is free or drains
  assign advance   = stg_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~stg_vld_r | advance;
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc)       stg_vld_nxt = 1'b1;
    else if (advance) stg_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (advance)         out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input item register
  always_ff @(posedge clk) begin
    if (in_acc) stg_tick_r <= in_tdata[0];
  end

  irpd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance & stg_tick_r),
    .cfg           (cfg),
    .carrier_on    (carrier_on),
    .phase         (phase),
    .byte_position (byte_position),
    .bit_position  (bit_position)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, bit_position, byte_position, phase, carrier_on};

endmodule
